// File: design/srs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants for the sorted range first/last search block.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int IDX_WIDTH  = 10;
  localparam int DATA_WIDTH = 32;
  // search bounds run from -1 up to 1024: signed, one bit of headroom
  localparam int SRCH_W     = IDX_WIDTH + 2;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam logic PASS_FIRST = 1'b0;
  localparam logic PASS_LAST  = 1'b1;

  typedef logic        [IDX_WIDTH-1:0]  idx_t;
  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [SRCH_W-1:0]     srch_t;

  typedef struct packed {
    logic load;   // capture an accepted word
    logic write;  // accepted word is a store write
    logic init;   // start a search pass from the captured range
    logic probe;  // one compare step of the current pass
    logic pass;   // PASS_FIRST or PASS_LAST
    logic emit;   // drive the result strobe
  } srs_cmd_t;

  typedef struct packed {
    logic range_done;  // low bound crossed high bound
  } srs_stat_t;

  function automatic srch_t mid_of(srch_t lo, srch_t hi);
    srch_t diff;
    diff = hi - lo;
    return lo + (diff >>> 1);
  endfunction

endpackage

// File: design/sorted_range_first_last_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_range_first_last_search
// Store of signed words with first/last occurrence binary search.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken at a clock edge with start high and busy low.
//   in_action = write: in_data_value goes to entry in_elem_index (ignored
//     past the store), written at the accepting edge; busy stays low.
//   in_action = search: two binary passes over [in_range_low, in_range_high]
//     (top clamped to the last entry), one for the first and one for the
//     last entry equal to in_data_value. The read port of the store is
//     registered; each pass is a bound load, the probes and an end check,
//     and an empty range goes straight to the end check. out_valid is
//     registered from the finish state that follows the second pass; busy
//     is high from the accept until then and drops in the out_valid cycle,
//     so the next word can be taken at its closing edge.
//   Result: out_valid strobes one cycle with out_found, out_first_index and
//     out_last_index (indices zero when not found or range empty). The
//     receiver must take it in that cycle; it cannot stall.
//   Reset clears the sequencer and the strobe; store contents are undefined
//   until written and the store is expected to be filled in sorted order.
// ----------------------------------------------------------------------------
module sorted_range_first_last_search #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic           in_action,
  input  srs_pkg::idx_t  in_elem_index,
  input  srs_pkg::data_t in_data_value,
  input  srs_pkg::idx_t  in_range_low,
  input  srs_pkg::idx_t  in_range_high,
  output logic           out_valid,
  output logic           out_found,
  output srs_pkg::idx_t  out_first_index,
  output srs_pkg::idx_t  out_last_index
);
  import srs_pkg::*;

  srs_cmd_t  cmd;
  srs_stat_t stat;

  srs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  srs_dpath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_elem_index   (in_elem_index),
    .in_data_value   (in_data_value),
    .in_range_low    (in_range_low),
    .in_range_high   (in_range_high),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_first_index (out_first_index),
    .out_last_index  (out_last_index)
  );

endmodule

// File: design/srs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_ctrl
// Sequencer: two binary search passes over the store, then one result strobe.
// ----------------------------------------------------------------------------
module srs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_action,
  input  srs_pkg::srs_stat_t stat,
  output srs_pkg::srs_cmd_t  cmd,
  output logic              busy
);
  import srs_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INIT   = 2'd1;
  localparam logic [1:0] ST_PROBE  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       pass_r, pass_nxt;
  logic       accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    cmd.pass  = pass_r;
    case (state_r)
      ST_IDLE: begin
        cmd.load  = accept;
        cmd.write = accept && (in_action == ACT_WRITE);
        if (accept && (in_action == ACT_SEARCH)) begin
          state_nxt = ST_INIT;
          pass_nxt  = PASS_FIRST;
        end
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (stat.range_done) begin
          if (pass_r == PASS_FIRST) begin
            pass_nxt  = PASS_LAST;
            state_nxt = ST_INIT;
          end else begin
            state_nxt = ST_FINISH;
          end
        end else begin
          cmd.probe = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= PASS_FIRST;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

endmodule

// File: design/srs_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_dpath
// Element store, search bounds, compare step and result registers.
// ----------------------------------------------------------------------------
module srs_dpath #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  srs_pkg::idx_t     in_elem_index,
  input  srs_pkg::data_t    in_data_value,
  input  srs_pkg::idx_t     in_range_low,
  input  srs_pkg::idx_t     in_range_high,
  input  srs_pkg::srs_cmd_t cmd,
  output srs_pkg::srs_stat_t stat,
  output logic              out_valid,
  output logic              out_found,
  output srs_pkg::idx_t     out_first_index,
  output srs_pkg::idx_t     out_last_index
);
  import srs_pkg::*;

  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [DATA_WIDTH-1:0] mem [STORE_DEPTH];
  data_t                 rd_q;

  data_t key_r;
  srch_t rlo_r, rhi_r;
  srch_t lo_r, lo_nxt;
  srch_t hi_r, hi_nxt;
  srch_t mid, mid_nxt;
  logic  first_vld_r, last_vld_r;
  idx_t  first_r, last_r;
  logic  out_valid_r, out_found_r;
  idx_t  out_first_r, out_last_r;

  logic [31:0]       hi_ext, hi_sat, wr_ext, rd_ext;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              wr_ok;
  logic              eq, gt;

  // clamp the top of the range to the last store entry
  assign hi_ext = 32'(in_range_high);
  assign hi_sat = (hi_ext > 32'(STORE_DEPTH - 1)) ? 32'(STORE_DEPTH - 1) : hi_ext;

  assign wr_ext  = 32'(in_elem_index);
  assign wr_ok   = wr_ext < 32'(STORE_DEPTH);
  assign wr_addr = wr_ext[ADDR_W-1:0];

  assign stat.range_done = (lo_r > hi_r);

  assign mid = mid_of(lo_r, hi_r);
  assign eq  = (rd_q == key_r);
  assign gt  = (rd_q > key_r);

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.init) begin
      lo_nxt = rlo_r;
      hi_nxt = rhi_r;
    end else if (cmd.probe) begin
      if (eq) begin
        if (cmd.pass == PASS_FIRST) hi_nxt = mid - srch_t'(1);
        else                        lo_nxt = mid + srch_t'(1);
      end else if (gt) begin
        hi_nxt = mid - srch_t'(1);
      end else begin
        lo_nxt = mid + srch_t'(1);
      end
    end
  end

  // address of the next probe goes out as the bounds update, so data is
  // ready in the following cycle; it is a don't-care once the bounds cross
  assign mid_nxt = mid_of(lo_nxt, hi_nxt);
  assign rd_ext  = 32'(mid_nxt);
  assign rd_addr = rd_ext[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      mem[wr_addr] <= in_data_value;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_data_value;
      rlo_r <= srch_t'(in_range_low);
      rhi_r <= srch_t'(hi_sat);
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.probe && eq) begin
      if (cmd.pass == PASS_FIRST) first_r <= mid[IDX_WIDTH-1:0];
      else                        last_r  <= mid[IDX_WIDTH-1:0];
    end
    if (cmd.emit) begin
      out_found_r <= first_vld_r && last_vld_r;
      out_first_r <= (first_vld_r && last_vld_r) ? first_r : '0;
      out_last_r  <= (first_vld_r && last_vld_r) ? last_r  : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_vld_r <= 1'b0;
      last_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.init) begin
        if (cmd.pass == PASS_FIRST) first_vld_r <= 1'b0;
        else                        last_vld_r  <= 1'b0;
      end else if (cmd.probe && eq) begin
        if (cmd.pass == PASS_FIRST) first_vld_r <= 1'b1;
        else                        last_vld_r  <= 1'b1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_first_index = out_first_r;
  assign out_last_index  = out_last_r;

endmodule
